>>> hdl/matrix_inverse_4x4_defines.svh
// Assertion macros used by the controller RTL.
`ifndef MATRIX_INVERSE_4X4_DEFINES_SVH
`define MATRIX_INVERSE_4X4_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define MI4_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define MI4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mi4_pkg.sv
`default_nettype none
package mi4_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLRA,
    ST_CLRD,
    ST_OPB,
    ST_OPA,
    ST_MUL,
    ST_NEXT,
    ST_STCOF,
    ST_DET,
    ST_DIVLD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    B_ELEM,
    B_TMP,
    B_COF
  } bsel_t;

  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_addr;
    logic [3:0] rd_addr;
    logic [3:0] cof_addr;
    logic       ldb;
    bsel_t      bsel;
    logic       lda;
    logic       mul_step;
    logic       mul_last;
    logic       dst_acc;
    logic       op_sub;
    logic       clr_tmp;
    logic       clr_acc;
    logic       st_cof;
    logic       neg_cof;
    logic       det_latch;
    logic       div_load;
    logic       div_step;
    logic       emit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic singular;
  } stat_t;

  // Index 0..2 into the set 0..3 with one member removed.
  function automatic logic [1:0] pick(input logic [1:0] excl, input logic [1:0] idx);
    pick = (idx < excl) ? idx : idx + 2'd1;
  endfunction

endpackage
`default_nettype wire

>>> hdl/mi4_dp.sv
`default_nettype none
module mi4_dp
  import mi4_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cmd_t                         cmd,
  input  wire logic signed [DATA_WIDTH-1:0] in_matrix_element,
  output stat_t                             stat,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_result_element,
  output logic        [3:0]                 out_element_index,
  output logic                              out_singular,
  output logic                              out_overflow,
  output logic                              out_last
);

  localparam int D  = DATA_WIDTH;
  localparam int W  = 4 * DATA_WIDTH + 5;
  localparam int CW = 3 * DATA_WIDTH + 3;
  localparam int NW = CW + 2 * FRAC_BITS;

  logic [D-1:0]  mat_r [16];
  logic [CW-1:0] cof_r [16];
  logic [W-1:0]  mb_r, tmp_r, acc_r, dabs_r;
  logic [D-1:0]  ma_r, q_r;
  logic [NW-1:0] num_r;
  logic [W-1:0]  rem_r;
  logic          big_r, neg_r, dneg_r, sing_r;
  logic          out_valid_r;
  logic [D-1:0]  out_res_r;
  logic [3:0]    out_idx_r;
  logic          out_sing_r, out_ovf_r, out_last_r;

  logic [D-1:0]  elem_rd;
  logic [W-1:0]  elem_ext;
  logic [CW-1:0] cof_rd, cof_abs, cof_wr;
  logic [W-1:0]  cof_ext, addend, dst_cur, dst_new, acc_neg;
  logic          sub_eff;
  logic [W:0]    rem_sh, rem_sub;
  logic          ge;
  logic [D-1:0]  lim_v, mag, res;
  logic          sat;

  // Read stores, extend operands
  always_comb begin
    elem_rd  = mat_r[cmd.rd_addr];
    elem_ext = {{(W-D){elem_rd[D-1]}}, elem_rd};
    cof_rd   = cof_r[cmd.cof_addr];
    cof_ext  = {{(W-CW){cof_rd[CW-1]}}, cof_rd};
    cof_abs  = cof_rd[CW-1] ? (~cof_rd + 1'b1) : cof_rd;
  end

  // Shift-add multiply step: add or subtract one partial product
  always_comb begin
    addend  = ma_r[0] ? mb_r : '0;
    sub_eff = cmd.op_sub ^ cmd.mul_last;
    dst_cur = cmd.dst_acc ? acc_r : tmp_r;
    dst_new = sub_eff ? (dst_cur - addend) : (dst_cur + addend);
    acc_neg = ~acc_r + 1'b1;
    cof_wr  = cmd.neg_cof ? acc_neg[CW-1:0] : acc_r[CW-1:0];
  end

  // Restoring divide step and saturation
  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    rem_sub = rem_sh - {1'b0, dabs_r};
    ge      = (rem_sh >= {1'b0, dabs_r});
    lim_v   = neg_r ? {1'b1, {(D-1){1'b0}}} : {1'b0, {(D-1){1'b1}}};
    sat     = big_r | (q_r > lim_v);
    mag     = sat ? lim_v : q_r;
    res     = neg_r ? (~mag + 1'b1) : mag;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mat_r[cmd.wr_addr] <= in_matrix_element;
    end
    if (cmd.st_cof) begin
      cof_r[cmd.cof_addr] <= cof_wr;
    end
    if (cmd.ldb) begin
      case (cmd.bsel)
        B_ELEM:  mb_r <= elem_ext;
        B_TMP:   mb_r <= tmp_r;
        B_COF:   mb_r <= cof_ext;
        default: mb_r <= elem_ext;
      endcase
    end else if (cmd.mul_step) begin
      mb_r <= {mb_r[W-2:0], 1'b0};
    end
    if (cmd.lda) begin
      ma_r <= elem_rd;
    end else if (cmd.mul_step) begin
      ma_r <= {1'b0, ma_r[D-1:1]};
    end
    if (cmd.clr_tmp) begin
      tmp_r <= '0;
    end else if (cmd.mul_step && !cmd.dst_acc) begin
      tmp_r <= dst_new;
    end
    if (cmd.clr_acc) begin
      acc_r <= '0;
    end else if (cmd.mul_step && cmd.dst_acc) begin
      acc_r <= dst_new;
    end
    if (cmd.det_latch) begin
      sing_r <= (acc_r == '0);
      dneg_r <= acc_r[W-1];
      dabs_r <= acc_r[W-1] ? acc_neg : acc_r;
    end
    if (cmd.div_load) begin
      num_r <= NW'(cof_abs) << (2 * FRAC_BITS);
      rem_r <= '0;
      q_r   <= '0;
      big_r <= 1'b0;
      neg_r <= cof_rd[CW-1] ^ dneg_r;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      rem_r <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      q_r   <= {q_r[D-2:0], ge};
      big_r <= big_r | q_r[D-1];
    end
    if (cmd.emit) begin
      out_res_r  <= sing_r ? elem_rd : res;
      out_idx_r  <= cmd.cof_addr;
      out_sing_r <= sing_r;
      out_ovf_r  <= !sing_r && sat;
      out_last_r <= cmd.last;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign stat.singular      = sing_r;
  assign out_valid          = out_valid_r;
  assign out_result_element = out_res_r;
  assign out_element_index  = out_idx_r;
  assign out_singular       = out_sing_r;
  assign out_overflow       = out_ovf_r;
  assign out_last           = out_last_r;

endmodule
`default_nettype wire

>>> hdl/mi4_ctrl.sv
`default_nettype none
`include "matrix_inverse_4x4_defines.svh"
module mi4_ctrl
  import mi4_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire stat_t stat,
  output logic       busy,
  output cmd_t       cmd
);

  localparam int NW    = 3 * DATA_WIDTH + 3 + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(NW);

  state_t           state_r, state_nxt;
  logic [3:0]       lc_r, lc_nxt, k_r, k_nxt;
  logic [1:0]       j_r, j_nxt, p_r, p_nxt;
  logic [CNT_W-1:0] bit_r, bit_nxt;
  logic             det_r, det_nxt;

  logic [1:0] r_sel, c_sel, j1, j2;
  logic [1:0] row0, row1, row2;
  logic [3:0] addr_a, addr_b;
  logic       mul_last;

  // Element addresses of the current minor term
  always_comb begin
    r_sel = k_r[3:2];
    c_sel = k_r[1:0];
    j1    = (j_r == 2'd2) ? 2'd0 : j_r + 2'd1;
    j2    = (j_r == 2'd0) ? 2'd2 : j_r - 2'd1;
    row0  = pick(c_sel, 2'd0);
    row1  = pick(c_sel, 2'd1);
    row2  = pick(c_sel, 2'd2);
    case (p_r)
      2'd0: begin
        addr_b = {row2, pick(r_sel, j2)};
        addr_a = {row1, pick(r_sel, j1)};
      end
      2'd1: begin
        addr_b = {row2, pick(r_sel, j1)};
        addr_a = {row1, pick(r_sel, j2)};
      end
      default: begin
        addr_b = '0;
        addr_a = {row0, pick(r_sel, j_r)};
      end
    endcase
    if (det_r) begin
      addr_a = {k_r[1:0], 2'b00};
    end
    mul_last = (bit_r == CNT_W'(DATA_WIDTH - 1));
  end

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    lc_nxt    = lc_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    p_nxt     = p_r;
    bit_nxt   = bit_r;
    det_nxt   = det_r;
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          lc_nxt = lc_r + 4'd1;
          if (lc_r == 4'd15) begin
            k_nxt     = '0;
            det_nxt   = 1'b0;
            state_nxt = ST_CLRA;
          end
        end
      end
      ST_CLRA: begin
        j_nxt     = '0;
        p_nxt     = '0;
        state_nxt = ST_OPB;
      end
      ST_CLRD: begin
        state_nxt = ST_OPB;
      end
      ST_OPB: begin
        state_nxt = ST_OPA;
      end
      ST_OPA: begin
        bit_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_last) begin
          state_nxt = ST_NEXT;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_NEXT: begin
        if (det_r) begin
          if (k_r == 4'd3) begin
            state_nxt = ST_DET;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = ST_OPB;
          end
        end else if (p_r != 2'd2) begin
          p_nxt     = p_r + 2'd1;
          state_nxt = ST_OPB;
        end else begin
          p_nxt = '0;
          if (j_r != 2'd2) begin
            j_nxt     = j_r + 2'd1;
            state_nxt = ST_OPB;
          end else begin
            state_nxt = ST_STCOF;
          end
        end
      end
      ST_STCOF: begin
        if (k_r == 4'd15) begin
          k_nxt     = '0;
          det_nxt   = 1'b1;
          state_nxt = ST_CLRD;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = ST_CLRA;
        end
      end
      ST_DET: begin
        k_nxt     = '0;
        state_nxt = ST_DIVLD;
      end
      ST_DIVLD: begin
        bit_nxt   = '0;
        state_nxt = stat.singular ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (bit_r == CNT_W'(NW - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_EMIT: begin
        k_nxt     = k_r + 4'd1;
        state_nxt = (k_r == 4'd15) ? ST_LOAD : ST_DIVLD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd          = '0;
    cmd.bsel     = B_ELEM;
    cmd.wr_addr  = lc_r;
    cmd.cof_addr = k_r;
    cmd.rd_addr  = k_r;
    busy         = (state_r != ST_LOAD);
    case (state_r)
      ST_LOAD: begin
        cmd.wr_en = start;
      end
      ST_CLRA, ST_CLRD: begin
        cmd.clr_acc = 1'b1;
      end
      ST_OPB: begin
        cmd.ldb     = 1'b1;
        cmd.rd_addr = addr_b;
        if (det_r) begin
          cmd.bsel = B_COF;
        end else if (p_r == 2'd2) begin
          cmd.bsel = B_TMP;
        end else begin
          cmd.bsel = B_ELEM;
        end
        cmd.clr_tmp = !det_r && (p_r == 2'd0);
      end
      ST_OPA: begin
        cmd.lda     = 1'b1;
        cmd.rd_addr = addr_a;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.mul_last = mul_last;
        cmd.dst_acc  = det_r || (p_r == 2'd2);
        cmd.op_sub   = !det_r && (p_r == 2'd1);
      end
      ST_STCOF: begin
        cmd.st_cof  = 1'b1;
        cmd.neg_cof = k_r[2] ^ k_r[0];
      end
      ST_DET: begin
        cmd.det_latch = 1'b1;
      end
      ST_DIVLD: begin
        cmd.div_load = !stat.singular;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.last = (k_r == 4'd15);
      end
      default: begin
        cmd.wr_en = 1'b0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      lc_r    <= '0;
      k_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
      bit_r   <= '0;
      det_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
      bit_r   <= bit_nxt;
      det_r   <= det_nxt;
    end
  end

  `MI4_ASSERT_NEXT(a_last_frees, cmd.emit && cmd.last, !busy, "last result did not free block")
  `MI4_ASSERT_IMPL(a_div_nonsing, cmd.div_step, !stat.singular, "divide on singular matrix")
  `MI4_ASSERT_NEXT(a_full_load, !busy && start && (lc_r == 4'd15), state_r == ST_CLRA,
                   "sixteenth request did not start compute")
  `MI4_ASSERT_NEXT(a_mul_hold, cmd.mul_step, $stable(k_r), "cofactor index moved mid-multiply")

endmodule
`default_nettype wire

>>> hdl/matrix_inverse_4x4.sv
`default_nettype none
// 4x4 fixed-point matrix inverse by cofactors. Send sixteen signed Q16.16
// elements in array order, one per request (start high while busy is low).
// After the sixteenth the block computes all cofactors and the determinant
// exactly with one shared shift-add multiplier (148 products), then
// divides each cofactor with a restoring divider. No new matrix is taken
// until the last result has been emitted. Results come out in array
// order, one per out_valid pulse, and cannot be stalled: the receiver must
// take each on the cycle it is shown. A singular matrix returns its own
// elements with out_singular set.
module matrix_inverse_4x4
  import mi4_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] in_matrix_element,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_result_element,
  output logic        [3:0]                 out_element_index,
  output logic                              out_singular,
  output logic                              out_overflow,
  output logic                              out_last
);

  cmd_t  cmd;
  stat_t stat;

  mi4_ctrl #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  mi4_dp #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_matrix_element (in_matrix_element),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_result_element(out_result_element),
    .out_element_index (out_element_index),
    .out_singular      (out_singular),
    .out_overflow      (out_overflow),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire

>>> test/tb_matrix_inverse_4x4.sv
`default_nettype none
module tb_matrix_inverse_4x4;
  import mi4_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int ELEMS = 16;
  localparam int RANDOM_MATRICES = 15;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [DW-1:0] value;
    logic [3:0]           index;
    logic                 singular;
    logic                 overflow;
    logic                 last;
  } inverse_elem_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [DW-1:0] in_matrix_element;
  logic                 out_valid;
  logic signed [DW-1:0] out_result_element;
  logic [3:0]           out_element_index;
  logic                 out_singular;
  logic                 out_overflow;
  logic                 out_last;

  matrix_inverse_4x4 #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_matrix_element(in_matrix_element),
    .out_valid(out_valid),
    .out_result_element(out_result_element),
    .out_element_index(out_element_index),
    .out_singular(out_singular),
    .out_overflow(out_overflow),
    .out_last(out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state: the matrix being loaded and its fill level.
  wide_t          loaded_matrix[ELEMS];
  int             fill_level;
  inverse_elem_t  pending_inverse[$];
  int             mismatches;
  int             results_seen;
  int             matrices_sent;
  int             singular_seen;
  int             overflow_seen;
  longint         cycle_count;
  bit             use_typed_expect;
  logic signed [DW-1:0] typed_expect[ELEMS];

  // Signed 3x3 minor of the adjugate entry (r,c): drop row c and column r.
  function automatic wide_t adjugate_entry(input int r, input int c);
    int    rows[3];
    int    cols[3];
    int    n;
    wide_t m[3][3];
    wide_t acc;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != c) begin
      rows[n] = k;
      n++;
    end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != r) begin
      cols[n] = k;
      n++;
    end
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) m[k][j] = loaded_matrix[rows[k] * 4 + cols[j]];
    acc = '0;
    for (int j = 0; j < 3; j++)
      acc += m[0][j] * (m[1][(j+1)%3] * m[2][(j+2)%3] - m[1][(j+2)%3] * m[2][(j+1)%3]);
    if ((r + c) & 1) acc = -acc;
    return acc;
  endfunction

  // Build the sixteen expected results for the loaded matrix.
  task automatic predict_inverse();
    wide_t         adj[ELEMS];
    wide_t         det;
    wide_t         det_mag;
    wide_t         num;
    wide_t         quo;
    wide_t         lim;
    logic          neg;
    inverse_elem_t e;
    det = '0;
    for (int k = 0; k < ELEMS; k++) adj[k] = adjugate_entry(k >> 2, k & 3);
    for (int k = 0; k < 4; k++) det += loaded_matrix[k * 4] * adj[k];
    det_mag = det[255] ? -det : det;
    for (int k = 0; k < ELEMS; k++) begin
      e.index = 4'(k);
      e.last = (k == ELEMS - 1);
      e.overflow = 1'b0;
      e.singular = (det == 0);
      if (e.singular) begin
        e.value = loaded_matrix[k][DW-1:0];
      end else begin
        neg = adj[k][255] != det[255];
        lim = neg ? (wide_t'(1) <<< (DW - 1)) : ((wide_t'(1) <<< (DW - 1)) - 1);
        num = (adj[k][255] ? -adj[k] : adj[k]) << (2 * FB);
        quo = wide_t'($unsigned(num) / $unsigned(det_mag));
        if ($unsigned(quo) > $unsigned(lim)) begin
          quo = lim;
          e.overflow = 1'b1;
        end
        e.value = neg ? DW'(-quo) : DW'(quo);
      end
      if (use_typed_expect) e.value = typed_expect[k];
      pending_inverse.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    inverse_elem_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_inverse.size() == 0) begin
        report_mismatch("unexpected result, index", out_element_index, 0);
      end else begin
        e = pending_inverse.pop_front();
        if (out_result_element !== e.value)
          report_mismatch("result_element", out_result_element, e.value);
        if (out_element_index !== e.index)
          report_mismatch("element_index", out_element_index, e.index);
        if (out_singular !== e.singular) report_mismatch("singular", out_singular, e.singular);
        if (out_overflow !== e.overflow) report_mismatch("overflow", out_overflow, e.overflow);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
        if (e.singular) singular_seen++;
        if (e.overflow) overflow_seen++;
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Send one request and wait for its acceptance; optionally idle after it.
  task automatic send_element(input logic signed [DW-1:0] value, input bit allow_idle);
    start <= 1'b1;
    in_matrix_element <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    loaded_matrix[fill_level] = value;
    fill_level++;
    if (fill_level == ELEMS) begin
      fill_level = 0;
      matrices_sent++;
      predict_inverse();
    end
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      in_matrix_element <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Directed matrix: four equal rows of field extremes, hence singular and echoed back.
  logic signed [DW-1:0] extreme_rows[ELEMS] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0001,
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0001,
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0001,
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0001
  };

  // Random matrix element by shape: full range, diagonally dominant, small integers,
  // tiny values (huge inverse), or a repeated row.
  function automatic logic signed [DW-1:0] shaped_element(input int shape, input int pos,
                                                          input logic signed [DW-1:0] above);
    case (shape)
      0: return $urandom;
      1: return (pos % 5 == 0) ? DW'($urandom_range(32'h0001_0000, 32'h0008_0000)) *
                                 ($urandom_range(0, 1) ? 1 : -1)
                               : DW'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
      2: return DW'(($signed($urandom_range(0, 8)) - 4) <<< FB);
      3: return DW'($signed($urandom_range(0, 64)) - 32);
      default: return (pos >= 12) ? above : DW'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [DW-1:0] row_buf[ELEMS];
    int shape;
    rst_n = 1'b0;
    start = 1'b0;
    in_matrix_element = '0;
    fill_level = 0;
    mismatches = 0;
    results_seen = 0;
    matrices_sent = 0;
    singular_seen = 0;
    overflow_seen = 0;
    cycle_count = 0;
    use_typed_expect = 1'b1;
    typed_expect = extreme_rows;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: walk the stimulus table.
    for (int k = 0; k < ELEMS; k++) send_element(extreme_rows[k], 1'b1);
    use_typed_expect = 1'b0;

    // Random matrices; the last one runs with no idling.
    for (int m = 0; m < RANDOM_MATRICES; m++) begin
      shape = (m < 5) ? m : $urandom_range(0, 4);
      for (int k = 0; k < ELEMS; k++) begin
        row_buf[k] = shaped_element(shape, k, (k >= 4) ? row_buf[k - 4] : '0);
        send_element(row_buf[k], m < RANDOM_MATRICES - 1);
      end
    end
    start <= 1'b0;

    // Drain, then let trailing activity settle.
    while (pending_inverse.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("sent %0d matrices, checked %0d results (%0d singular, %0d saturated)",
             matrices_sent, results_seen, singular_seen, overflow_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/mi4_pkg.sv
hdl/mi4_dp.sv
hdl/mi4_ctrl.sv
hdl/matrix_inverse_4x4.sv
test/tb_matrix_inverse_4x4.sv
